// ===== src/cfr_pkg.sv =====
package cfr_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TAIL_BYTE = 8'hbb;
    localparam logic [7:0] EXT_MARK  = 8'hfd;
    localparam logic [7:0] BASE_LEN  = 8'd8;

    localparam logic [7:0] CODE_STATUS   = 8'h80;
    localparam logic [7:0] CODE_RFID     = 8'h81;
    localparam logic [7:0] CODE_REGULAR0 = 8'h82;
    localparam logic [7:0] CODE_REGULAR1 = 8'h83;

    // Bytes 0..6 of a frame are kept; later bytes only matter as the tail.
    localparam int HEAD_LEN = 7;
    localparam int CMD_LEN  = 5;

    typedef logic [HEAD_LEN-1:0][7:0] head_t;
    typedef logic [CMD_LEN-1:0][7:0]  cmd_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_NEW_CMD     = 4'd1,
        EV_REP_STATUS  = 4'd2,
        EV_REP_RFID    = 4'd3,
        EV_REP_REGULAR = 4'd4,
        EV_REP_ACK     = 4'd5,
        EV_SUM_ERR     = 4'd6,
        EV_EXT_DONE    = 4'd7,
        EV_FRAME_ERR   = 4'd8,
        EV_EXT_SHORT   = 4'd9
    } event_t;

    typedef enum logic {
        REQ_BYTE      = 1'b0,
        REQ_SET_READY = 1'b1
    } req_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        event_t     event_res;
        logic       byte_taken;
        logic [7:0] byte_position;
        logic [7:0] frame_length;
        logic [7:0] cmd_byte1;
        logic [7:0] cmd_byte2;
        logic [7:0] cmd_byte3;
        logic [7:0] cmd_byte4;
        logic [7:0] cmd_byte5;
    } out_word_t;

    // Decision taken when the last byte of a frame arrives.
    typedef struct packed {
        event_t     event_res;
        logic       count_clear;
        logic       ext_set;
        logic       ext_clear;
        logic       len_load;
        logic [7:0] len_value;
        logic [7:0] frame_len;
        logic       cmd_out;
        logic       cmd_latch;
    } finish_t;

endpackage

// ===== src/cfr_frame_check.sv =====
module cfr_frame_check (
    input  cfr_pkg::head_t   head,
    input  cfr_pkg::cmd_t    last_cmd,
    input  logic [7:0]       rx_byte,
    input  logic             extended_mode,
    input  logic [7:0]       expected_length,
    output cfr_pkg::finish_t fin
);
    import cfr_pkg::*;

    logic       tail_ok;
    logic       ext_mark;
    logic [7:0] sum;
    logic       differs;
    event_t     repeat_ev;

    assign tail_ok  = (rx_byte == TAIL_BYTE);
    assign ext_mark = (head[1] == EXT_MARK);
    assign sum      = 8'(head[2] + head[3] + head[4] + head[5]);
    assign differs  = (head[5:1] != last_cmd);

    always_comb
    begin
        priority if (head[2] == CODE_STATUS)
            repeat_ev = EV_REP_STATUS;
        else if (head[2] == CODE_RFID)
            repeat_ev = EV_REP_RFID;
        else if (head[2] == CODE_REGULAR0 || head[2] == CODE_REGULAR1)
            repeat_ev = EV_REP_REGULAR;
        else
            repeat_ev = EV_REP_ACK;
    end

    always_comb
    begin
        fin             = '0;
        fin.event_res   = EV_NONE;
        fin.len_value   = BASE_LEN;
        fin.frame_len   = expected_length;
        priority if (tail_ok && !extended_mode && !ext_mark)
        begin
            fin.count_clear = 1'b1;
            if (sum == head[6])
            begin
                fin.cmd_out   = 1'b1;
                fin.cmd_latch = differs;
                fin.event_res = differs ? EV_NEW_CMD : repeat_ev;
            end
            else
            begin
                fin.event_res = EV_SUM_ERR;
            end
        end
        else if (ext_mark && !extended_mode)
        begin
            if (head[2] > BASE_LEN)
            begin
                // Extension request: keep collecting up to the new length.
                fin.ext_set   = 1'b1;
                fin.len_load  = 1'b1;
                fin.len_value = head[2];
                fin.frame_len = head[2];
            end
            else
            begin
                fin.count_clear = 1'b1;
                if (tail_ok)
                begin
                    fin.len_load  = 1'b1;
                    fin.cmd_out   = 1'b1;
                    fin.event_res = EV_EXT_DONE;
                end
                else
                begin
                    fin.event_res = EV_EXT_SHORT;
                end
            end
        end
        else if (extended_mode && tail_ok)
        begin
            fin.count_clear = 1'b1;
            fin.ext_clear   = 1'b1;
            fin.len_load    = 1'b1;
            fin.cmd_out     = 1'b1;
            fin.event_res   = EV_EXT_DONE;
        end
        else
        begin
            fin.count_clear = 1'b1;
            fin.event_res   = EV_FRAME_ERR;
        end
    end

endmodule

// ===== src/command_frame_receiver.sv =====
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   in_data   (req_type, rx_byte)
// output    out        out_valid/out_stall out_data  (event and frame fields)
//
// Every accepted input word yields exactly one output word in the next cycle.
// The block takes one word per cycle unless stalled; the frame state update
// and the result are one pass of next-state logic into state/output registers.
// In_stall is raised only while a result is held and out_stall is high.
// Reset sets ready, clears the byte count, extended mode and the last command,
// and sets the expected length to eight; the stored frame bytes are not reset.
module command_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cfr_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cfr_pkg::out_word_t out_data
);
    import cfr_pkg::*;

    // Frame state.
    logic        ready_reg, ready_next;
    logic [7:0]  count_reg, count_next;
    logic        ext_reg, ext_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    head_t       head_reg, head_next;
    cmd_t        last_cmd_reg, last_cmd_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic        accept;
    logic        taken;
    logic        complete;
    finish_t     fin;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A byte is stored when ready and either a frame is open or it is a header.
    assign taken    = (in_data.req_type == REQ_BYTE) && ready_reg &&
                      (count_reg != 8'd0 || in_data.rx_byte == HDR_BYTE);
    assign complete = taken &&
                      ({1'b0, count_reg} + 9'd1 >= {1'b0, exp_len_reg});

    // The last byte of a frame always sits at position seven or later, so
    // the check sees only bytes stored in earlier cycles.
    cfr_frame_check u_check (
        .head            (head_reg),
        .last_cmd        (last_cmd_reg),
        .rx_byte         (in_data.rx_byte),
        .extended_mode   (ext_reg),
        .expected_length (exp_len_reg),
        .fin             (fin)
    );

    always_comb
    begin
        ready_next     = ready_reg;
        count_next     = count_reg;
        ext_next       = ext_reg;
        exp_len_next   = exp_len_reg;
        head_next      = head_reg;
        last_cmd_next  = last_cmd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next.event_res = EV_NONE;

            if (in_data.req_type == REQ_SET_READY)
                ready_next = 1'b1;

            if (taken)
            begin
                out_data_next.byte_taken    = 1'b1;
                out_data_next.byte_position = count_reg;
                if (count_reg < 8'(HEAD_LEN))
                    head_next[count_reg[2:0]] = in_data.rx_byte;
                count_next = 8'(count_reg + 8'd1);
            end

            if (complete)
            begin
                out_data_next.event_res    = fin.event_res;
                out_data_next.frame_length = fin.frame_len;
                if (fin.count_clear)
                    count_next = 8'd0;
                if (fin.ext_set)
                    ext_next = 1'b1;
                if (fin.ext_clear)
                    ext_next = 1'b0;
                if (fin.len_load)
                    exp_len_next = fin.len_value;
                if (fin.cmd_latch)
                begin
                    // A new command is latched and holds off further bytes.
                    ready_next    = 1'b0;
                    last_cmd_next = head_reg[5:1];
                end
                if (fin.cmd_out)
                begin
                    out_data_next.cmd_byte1 = head_reg[1];
                    out_data_next.cmd_byte2 = head_reg[2];
                    out_data_next.cmd_byte3 = head_reg[3];
                    out_data_next.cmd_byte4 = head_reg[4];
                    out_data_next.cmd_byte5 = head_reg[5];
                end
            end
            else
            begin
                out_data_next.frame_length = exp_len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= 1'b1;
            count_reg     <= 8'd0;
            ext_reg       <= 1'b0;
            exp_len_reg   <= BASE_LEN;
            last_cmd_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            ext_reg       <= ext_next;
            exp_len_reg   <= exp_len_next;
            last_cmd_reg  <= last_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        out_data_reg <= out_data_next;
    end

    // An open frame never reaches its expected length.
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < exp_len_reg)
        else $error("byte count reached the expected frame length");

    // Extended mode only runs with a length above the base frame.
    a_ext_len: assert property (@(posedge clk) disable iff (!rst_n)
        ext_reg |-> (exp_len_reg > BASE_LEN))
        else $error("extended mode with a base-length frame");

    // A new command leaves the block not ready.
    a_new_cmd_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && complete && fin.cmd_latch) |=> !ready_reg)
        else $error("ready still set after a new command");

endmodule
